### hdl/seven_segment_scan_writer_core_macros.svh
// Assertion macros used by the scan writer checker.
// Depends on nothing; included by the checker file.
`ifndef SEVEN_SEGMENT_SCAN_WRITER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_WRITER_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SSW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SSW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ssw_pkg.sv
// Shared types, constants and segment tables for the scan writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

    localparam int SSW_DIGITS = 4;
    localparam int SSW_PATS   = 4;

    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] SEL_NONE  = 8'h7F;

    localparam logic LATCH_SEG   = 1'b0;
    localparam logic LATCH_DIGIT = 1'b1;

    typedef struct packed {
        logic [SSW_PATS-1:0][7:0] pat;
    } ssw_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ssw_qstat_t;

    function automatic logic [7:0] numeral_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] letter_seg(input logic [3:0] idx);
        logic [7:0] s;
        case (idx)
            4'd0:    s = 8'h88;
            4'd1:    s = 8'h83;
            4'd2:    s = 8'hC6;
            4'd3:    s = 8'hA1;
            4'd4:    s = 8'h86;
            4'd5:    s = 8'h8E;
            4'd6:    s = 8'h90;
            4'd7:    s = 8'hA3;
            4'd8:    s = 8'hA1;
            4'd9:    s = 8'h89;
            4'd10:   s = 8'hC1;
            4'd11:   s = 8'h82;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/seven_segment_scan_writer_core.sv
// Flow: the front end accepts a request, converts it to BCD, pushes the pattern set into
// the queue, and the back end loads each latch write into the output register.
// A new request is taken once the last is pushed, while the back end still emits its writes,
// and a push stalls while the queue is full. Writes leave one per cycle while m_tready is high.
// Reset: rst_n clears control state and sets dwell_ticks to zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_scan_writer_core #(
    parameter int DIGITS = ssw_pkg::SSW_DIGITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[15:0], letter_first[19:16], letter_second[23:20],
                                   // letter_third[27:24], letter_fourth[31:28]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // bus_data[7:0], wait_after[22:8], zero[23]
    output logic [0:0]  m_tuser,   // latch_sel[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data   // dwell_ticks
);
    import ssw_pkg::*;

    ssw_qstat_t qstat;
    ssw_entry_t push_entry;
    ssw_entry_t head;
    logic       push;
    logic       pop;

    ssw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    ssw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    ssw_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### hdl/ssw_front.sv
// Front end: accepts display requests, converts to BCD and looks up patterns.
// Depends on ssw_pkg; pushes finished pattern sets into ssw_queue.
`timescale 1ns / 1ps
`default_nettype none

module ssw_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    input  ssw_pkg::ssw_qstat_t qstat,
    output logic               push,
    output ssw_pkg::ssw_entry_t push_entry
);
    import ssw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    localparam logic [1:0] KIND_DEC    = 2'd0;
    localparam logic [1:0] KIND_BYTES  = 2'd1;
    localparam logic [1:0] KIND_LETTER = 2'd2;

    // two shift-and-add-3 steps per cycle over 16 bits
    localparam int CONV_CYCLES = 8;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] let_reg, let_next;
    logic [35:0] a_reg, a_next;
    logic [35:0] b_reg, b_next;

    // one double-dabble step on {bcd[19:0], bin[15:0]}
    function automatic logic [35:0] dd_step(input logic [35:0] x);
        logic [35:0] y;
        y = x;
        for (int i = 0; i < 5; i++) begin
            if (y[16 + 4*i +: 4] >= 4'd5)
            begin
                y[16 + 4*i +: 4] = y[16 + 4*i +: 4] + 4'd3;
            end
        end
        return {y[34:0], 1'b0};
    endfunction

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        let_next   = let_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    let_next   = s_tdata[31:16];
                    // lane a takes the whole value or the high byte, lane b the low byte
                    a_next     = (s_tuser == KIND_DEC) ? {20'd0, s_tdata[15:0]}
                                                       : {20'd0, 8'd0, s_tdata[15:8]};
                    b_next     = {20'd0, 8'd0, s_tdata[7:0]};
                    cnt_next   = 3'd0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                a_next   = dd_step(dd_step(a_reg));
                b_next   = dd_step(dd_step(b_reg));
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(CONV_CYCLES - 1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!qstat.full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        let_reg  <= let_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign push     = (state_reg == ST_PUSH) && !qstat.full;

    always_comb
    begin
        case (kind_reg)
            KIND_DEC:
            begin
                // drop the ten-thousands digit
                push_entry.pat[0] = numeral_seg(a_reg[31:28]);
                push_entry.pat[1] = numeral_seg(a_reg[27:24]);
                push_entry.pat[2] = numeral_seg(a_reg[23:20]);
                push_entry.pat[3] = numeral_seg(a_reg[19:16]);
            end
            KIND_BYTES:
            begin
                push_entry.pat[0] = numeral_seg(a_reg[23:20]);
                push_entry.pat[1] = numeral_seg(a_reg[19:16]);
                push_entry.pat[2] = numeral_seg(b_reg[23:20]);
                push_entry.pat[3] = numeral_seg(b_reg[19:16]);
            end
            KIND_LETTER:
            begin
                push_entry.pat[0] = letter_seg(let_reg[3:0]);
                push_entry.pat[1] = letter_seg(let_reg[7:4]);
                push_entry.pat[2] = letter_seg(let_reg[11:8]);
                push_entry.pat[3] = letter_seg(let_reg[15:12]);
            end
            default:
            begin
                push_entry.pat[0] = SEG_BLANK;
                push_entry.pat[1] = SEG_BLANK;
                push_entry.pat[2] = SEG_BLANK;
                push_entry.pat[3] = SEG_BLANK;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/ssw_queue.sv
// Two-entry queue of pattern sets between the front and back ends.
// Depends on ssw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ssw_pkg::ssw_entry_t push_entry,
    input  logic                pop,
    output ssw_pkg::ssw_entry_t head,
    output ssw_pkg::ssw_qstat_t qstat
);
    import ssw_pkg::*;

    ssw_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

endmodule

`default_nettype wire

### hdl/ssw_back.sv
// Back end: walks the digits of the head entry and emits the latch writes.
// Depends on ssw_pkg; holds the dwell register and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ssw_back #(
    parameter int DIGITS = ssw_pkg::SSW_DIGITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [14:0]         cfg_data,
    input  ssw_pkg::ssw_qstat_t qstat,
    input  ssw_pkg::ssw_entry_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);
    import ssw_pkg::*;

    localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [1:0] PH_BLANK = 2'd0;
    localparam logic [1:0] PH_SEG   = 2'd1;
    localparam logic [1:0] PH_SEL   = 2'd2;

    logic [14:0]      dwell_reg;
    logic [DIG_W-1:0] digit_reg, digit_next;
    logic [1:0]       phase_reg, phase_next;
    logic             valid_reg, valid_next;
    logic [7:0]       data_reg;
    logic             sel_reg;
    logic [14:0]      wait_reg;
    logic             last_reg;

    logic             load;
    logic             last_digit;
    logic [2:0]       digit3;
    logic [7:0]       seg;
    logic [7:0]       w_data;
    logic             w_sel;
    logic [14:0]      w_wait;
    logic             w_last;

    assign cfg_ready  = 1'b1;
    assign load       = !qstat.empty && (!valid_reg || m_tready);
    assign last_digit = (digit_reg == DIG_W'(DIGITS - 1));
    assign digit3     = 3'(digit_reg);
    assign seg        = (digit3 < 3'(SSW_PATS)) ? head.pat[digit3[1:0]] : SEG_BLANK;

    always_comb
    begin
        case (phase_reg)
            PH_SEG:
            begin
                w_data = seg;
                w_sel  = LATCH_SEG;
                w_wait = 15'd0;
                w_last = 1'b0;
            end
            PH_SEL:
            begin
                w_data = ~(8'd1 << digit3);
                w_sel  = LATCH_DIGIT;
                w_wait = dwell_reg;
                w_last = last_digit;
            end
            default:
            begin
                // blank the display before changing segments
                w_data = SEL_NONE;
                w_sel  = LATCH_DIGIT;
                w_wait = 15'd0;
                w_last = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        digit_next = digit_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (phase_reg == PH_SEL)
            begin
                phase_next = PH_BLANK;
                if (last_digit)
                begin
                    // release the entry on its final write
                    digit_next = '0;
                    pop        = 1'b1;
                end
                else
                begin
                    digit_next = digit_reg + 1'b1;
                end
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_reg <= 15'd0;
            digit_reg <= '0;
            phase_reg <= PH_BLANK;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                dwell_reg <= cfg_data;
            end
            digit_reg <= digit_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= w_data;
            sel_reg  <= w_sel;
            wait_reg <= w_wait;
            last_reg <= w_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, wait_reg, data_reg};
    assign m_tuser  = sel_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### hdl/ssw_checker.sv
// Port-level checker for the scan writer output channel, bound to the top level.
// Depends on ssw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_scan_writer_core_macros.svh"

module ssw_checker #(
    parameter int DIGITS = ssw_pkg::SSW_DIGITS
) (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);
    import ssw_pkg::*;

    localparam logic [7:0] LAST_SEL = ~(8'd1 << (DIGITS - 1));

    `SSW_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled write changed")
    `SSW_ASSERT_IMP(a_last_form, clk, rst_n, m_tvalid && m_tlast, (m_tuser[0] == LATCH_DIGIT) && (m_tdata[7:0] == LAST_SEL), "last write is not the final digit select")
    `SSW_ASSERT_IMP(a_seg_no_wait, clk, rst_n, m_tvalid && (m_tuser[0] == LATCH_SEG), (m_tdata[22:8] == 15'd0) && !m_tlast, "segment write carries a wait or last")
    `SSW_ASSERT_NXT(a_seg_then_sel, clk, rst_n, m_tvalid && m_tready && (m_tuser[0] == LATCH_SEG), m_tvalid && (m_tuser[0] == LATCH_DIGIT), "segment write not followed by digit select")

endmodule

bind seven_segment_scan_writer_core ssw_checker #(
    .DIGITS (DIGITS)
) u_ssw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
